@@ rtl/core/tpfc_pkg.sv @@
// Shared types and constants for the texture pixel format converter.
package tpfc_pkg;

    typedef enum logic [2:0] {
        FMT_PASS     = 3'd0,
        FMT_A8       = 3'd1,
        FMT_L8       = 3'd2,
        FMT_RGB565   = 3'd3,
        FMT_RGB888   = 3'd4,
        FMT_RGBA4444 = 3'd5,
        FMT_RGBA8888 = 3'd6,
        FMT_DEPTH    = 3'd7
    } fmt_t;

    localparam logic [0:0] REG_TARGET_FORMAT   = 1'b0;
    localparam logic [0:0] REG_SOURCE_CHANNELS = 1'b1;

    localparam logic [2:0] CH_ONE   = 3'd1;
    localparam logic [2:0] CH_THREE = 3'd3;
    localparam logic [2:0] CH_FOUR  = 3'd4;

    localparam logic [2:0] FMT_RESET = 3'd0;
    localparam logic [2:0] CH_RESET  = 3'd4;

    // luma weights in percent
    localparam logic [4:0] WEIGHT_R = 5'd30;
    localparam logic [5:0] WEIGHT_G = 6'd59;
    localparam logic [3:0] WEIGHT_B = 4'd11;

    // floor(x / 100) = (x * DIV100_MUL) >> DIV100_SHIFT for x < 43690
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last_pixel;
        fmt_t       fmt;
        logic [2:0] channels;
    } pix_t;

endpackage

@@ rtl/core/tpfc_luma.sv @@
// Three-stage luma pipeline: weighted products, sum, divide by 100.
module tpfc_luma
(
    input  logic       clk,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output logic [7:0] gray
);

    logic [12:0] prod_r_reg;
    logic [13:0] prod_g_reg;
    logic [11:0] prod_b_reg;
    logic [14:0] sum_reg;
    logic [27:0] scaled_reg;
    logic [12:0] prod_r_next;
    logic [13:0] prod_g_next;
    logic [11:0] prod_b_next;
    logic [14:0] sum_next;
    logic [27:0] scaled_next;

    always_comb
    begin
        prod_r_next = 13'(red * tpfc_pkg::WEIGHT_R);
        prod_g_next = 14'(green * tpfc_pkg::WEIGHT_G);
        prod_b_next = 12'(blue * tpfc_pkg::WEIGHT_B);
        sum_next    = 15'(prod_r_reg) + 15'(prod_g_reg) + 15'(prod_b_reg);
        scaled_next = 28'(sum_reg) * 28'(tpfc_pkg::DIV100_MUL);
    end

    always_ff @(posedge clk)
    begin
        prod_r_reg <= prod_r_next;
        prod_g_reg <= prod_g_next;
        prod_b_reg <= prod_b_next;
        sum_reg    <= sum_next;
        scaled_reg <= scaled_next;
    end

    assign gray = scaled_reg[tpfc_pkg::DIV100_SHIFT +: 8];

endmodule

@@ rtl/core/tpfc_pack.sv @@
// Output stage: format selection, packing, error check and result register.
module tpfc_pack
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    input  tpfc_pkg::pix_t     pix,
    input  logic [7:0]         gray,
    output logic               done,
    output logic [31:0]        pixel_word,
    output logic [2:0]         byte_count,
    output logic               format_error,
    output logic               last_out
);

    logic        done_reg;
    logic [31:0] word_reg;
    logic [2:0]  count_reg;
    logic        err_reg;
    logic        last_reg;
    logic [31:0] word_next;
    logic [2:0]  count_next;
    logic        err_next;
    logic        ch_ok;
    logic        ch_one;
    logic        ch_three;
    logic [15:0] w565;
    logic [15:0] w4444;

    always_comb
    begin
        ch_one   = (pix.channels == tpfc_pkg::CH_ONE);
        ch_three = (pix.channels == tpfc_pkg::CH_THREE);
        ch_ok    = ch_one || ch_three || (pix.channels == tpfc_pkg::CH_FOUR);
        w565     = {pix.red[7:3], pix.green[7:2], pix.blue[7:3]};
        w4444    = {pix.red[7:4], pix.green[7:4], pix.blue[7:4], pix.alpha[7:4]};
        word_next  = '0;
        count_next = '0;
        err_next   = 1'b0;
        case (pix.fmt)
            tpfc_pkg::FMT_A8:
            begin
                count_next = 3'd1;
                if (ch_one)
                    word_next = {24'd0, pix.red};
                else if (ch_three)
                    word_next = {24'd0, gray};
                else
                    word_next = {24'd0, pix.alpha};
            end
            tpfc_pkg::FMT_L8:
            begin
                count_next = 3'd1;
                word_next  = ch_one ? {24'd0, pix.red} : {24'd0, gray};
            end
            tpfc_pkg::FMT_RGB565:
            begin
                err_next   = ch_one;
                count_next = 3'd2;
                word_next  = {16'd0, w565};
            end
            tpfc_pkg::FMT_RGB888:
            begin
                err_next   = ch_one;
                count_next = 3'd3;
                word_next  = {8'd0, pix.blue, pix.green, pix.red};
            end
            tpfc_pkg::FMT_RGBA4444:
            begin
                err_next   = ch_one;
                count_next = 3'd2;
                word_next  = ch_three ? {16'd0, w565} : {16'd0, w4444};
            end
            tpfc_pkg::FMT_RGBA8888:
            begin
                err_next   = ch_one;
                count_next = 3'd4;
                word_next  = {ch_three ? tpfc_pkg::ALPHA_OPAQUE : pix.alpha,
                              pix.blue, pix.green, pix.red};
            end
            default:
            begin
                count_next = pix.channels;
                if (ch_one)
                    word_next = {24'd0, pix.red};
                else if (ch_three)
                    word_next = {8'd0, pix.blue, pix.green, pix.red};
                else
                    word_next = {pix.alpha, pix.blue, pix.green, pix.red};
            end
        endcase
        if (!ch_ok)
            err_next = 1'b1;
        if (err_next)
        begin
            word_next  = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= valid;
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        count_reg <= count_next;
        err_reg   <= err_next;
        last_reg  <= pix.last_pixel;
    end

    assign done         = done_reg;
    assign pixel_word   = word_reg;
    assign byte_count   = count_reg;
    assign format_error = err_reg;
    assign last_out     = last_reg;

endmodule

@@ rtl/core/texture_pixel_format_converter_core.sv @@
// Top level of the texture pixel format converter.
//
// Input: an item is taken at a rising edge with start high and busy low.
// busy is always low, so one pixel may be started every cycle.
// Configuration: cfg_valid/cfg_ready write channel; cfg_index 0 selects
// target_format, 1 selects source_channels. cfg_ready is always high.
// Write configuration only while no item is in flight; each item samples
// the registers when it is started.
// Output: done is high for one cycle with pixel_word, byte_count,
// format_error and last_out. The receiver cannot stall; results are
// delivered in order, one per item.
// Pipeline: each item passes the registers for luma products, sum,
// divide by 100 via reciprocal multiply, and pack, in that order.
// Throughput: one pixel per cycle, set by the four-stage pipeline.
// Reset: pipeline valid bits cleared, target_format = 0, source_channels = 4.
module texture_pixel_format_converter_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [7:0]  alpha,
    input  logic        last_pixel,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [2:0]  cfg_data,
    output logic        done,
    output logic [31:0] pixel_word,
    output logic [2:0]  byte_count,
    output logic        format_error,
    output logic        last_out
);

    logic [2:0]     fmt_reg;
    logic [2:0]     ch_reg;
    logic [2:0]     valid_reg;
    tpfc_pkg::pix_t pix_reg [3];
    tpfc_pkg::pix_t pix_next;
    logic           accept;
    logic [7:0]     gray;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= tpfc_pkg::FMT_RESET;
            ch_reg  <= tpfc_pkg::CH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tpfc_pkg::REG_TARGET_FORMAT:   fmt_reg <= cfg_data;
                tpfc_pkg::REG_SOURCE_CHANNELS: ch_reg  <= cfg_data;
                default:                       ;
            endcase
        end
    end

    always_comb
    begin
        pix_next.red        = red;
        pix_next.green      = green;
        pix_next.blue       = blue;
        pix_next.alpha      = alpha;
        pix_next.last_pixel = last_pixel;
        pix_next.fmt        = tpfc_pkg::fmt_t'(fmt_reg);
        pix_next.channels   = ch_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[1:0], accept};
    end

    always_ff @(posedge clk)
    begin
        pix_reg[0] <= pix_next;
        pix_reg[1] <= pix_reg[0];
        pix_reg[2] <= pix_reg[1];
    end

    tpfc_luma u_luma
    (
        .clk   (clk),
        .red   (red),
        .green (green),
        .blue  (blue),
        .gray  (gray)
    );

    tpfc_pack u_pack
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid        (valid_reg[2]),
        .pix          (pix_reg[2]),
        .gray         (gray),
        .done         (done),
        .pixel_word   (pixel_word),
        .byte_count   (byte_count),
        .format_error (format_error),
        .last_out     (last_out)
    );

endmodule
